// File: sv/fica_pkg.sv
// Shared types and constants for the free inode cache allocator.
// Used by the controller, the datapath, the top level and the checker.
package fica_pkg;

  localparam int unsigned NUM_W      = 9;
  localparam int unsigned ROOT_INDEX = 1;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_LOAD,
    ST_POP,
    ST_REFILL
  } state_t;

  typedef struct packed {
    logic clr_step;
    logic scan_init;
    logic scan_step;
    logic pop;
    logic free_op;
    logic emit_fail;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic count_zero;
    logic count_one;
    logic scan_done;
    logic fill_empty;
  } status_t;

endpackage

// File: sv/fica_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fica_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/fica_ctrl.sv
// Controller state machine for the free inode cache allocator.
// Depends on fica_pkg; drives commands into fica_dp and reads its status.
module fica_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_op,
  input  fica_pkg::status_t status,
  output fica_pkg::cmd_t    cmd,
  output logic              busy
);
  import fica_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (status.clear_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start && in_op == OP_ALLOC) begin
          state_nxt = status.count_zero ? ST_FILL : ST_POP;
        end
      end
      ST_FILL: begin
        if (status.scan_done) begin
          state_nxt = status.fill_empty ? ST_IDLE : ST_LOAD;
        end
      end
      ST_LOAD: state_nxt = ST_POP;
      ST_POP: state_nxt = status.count_one ? ST_REFILL : ST_IDLE;
      ST_REFILL: begin
        if (status.scan_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state_r)
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.free_op   = (in_op == OP_FREE);
          cmd.scan_init = (in_op == OP_ALLOC) && status.count_zero;
        end
      end
      ST_FILL: begin
        cmd.scan_step = 1'b1;
        cmd.emit_fail = status.scan_done && status.fill_empty;
      end
      ST_LOAD: cmd = '0;
      ST_POP: begin
        cmd.pop       = 1'b1;
        cmd.scan_init = status.count_one;
      end
      ST_REFILL: cmd.scan_step = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

// File: sv/fica_dp.sv
// Datapath for the free inode cache allocator: bitmap RAM, free-number stack,
// refill scan and result registers. Depends on fica_pkg and fica_ram.
module fica_dp #(
  parameter int unsigned NUM_INODES  = 512,
  parameter int unsigned STACK_DEPTH = 100
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  fica_pkg::cmd_t               cmd,
  output fica_pkg::status_t            status,
  input  logic [fica_pkg::NUM_W-1:0]   in_inode_number,
  output logic                         out_valid,
  output logic [fica_pkg::NUM_W-1:0]   out_granted_number,
  output logic                         out_ok
);
  import fica_pkg::*;

  localparam int unsigned AW  = $clog2(NUM_INODES);
  localparam int unsigned SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW  = $clog2(STACK_DEPTH + 1);

  logic [CW-1:0]    count_r, count_nxt;
  logic [AW:0]      scan_addr_r, scan_addr_nxt;
  logic             pend_r, pend_nxt;
  logic [AW-1:0]    chk_addr_r, chk_addr_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [NUM_W-1:0] out_num_r, out_num_nxt;
  logic             out_ok_r, out_ok_nxt;

  logic             bm_we, bm_wdata, bm_rdata;
  logic [AW-1:0]    bm_waddr;
  logic             st_we;
  logic [SAW-1:0]   st_waddr, st_raddr;
  logic [AW-1:0]    st_wdata, st_rdata;

  logic             in_range, push, scan_issue, free_push;
  logic [AW-1:0]    num_w;
  logic [CW-1:0]    cnt_after;

  assign in_range   = 32'(in_inode_number) < NUM_INODES;
  assign num_w      = AW'(in_inode_number);
  assign push       = pend_r & ~bm_rdata;
  assign cnt_after  = count_r + CW'(push);
  assign scan_issue = (32'(scan_addr_r) < NUM_INODES) && (32'(cnt_after) < STACK_DEPTH);
  assign free_push  = cmd.free_op && in_range && (32'(count_r) < STACK_DEPTH);

  assign status.clear_done = (clr_addr_r == AW'(NUM_INODES - 1));
  assign status.count_zero = (count_r == '0);
  assign status.count_one  = (count_r == CW'(1));
  assign status.scan_done  = ~scan_issue;
  assign status.fill_empty = (cnt_after == '0);

  always_comb begin
    bm_we    = cmd.clr_step || cmd.pop || (cmd.free_op && in_range);
    bm_wdata = cmd.pop;
    if (cmd.clr_step) begin
      bm_waddr = clr_addr_r;
    end else if (cmd.pop) begin
      bm_waddr = st_rdata;
    end else begin
      bm_waddr = num_w;
    end
  end

  always_comb begin
    st_we    = (cmd.scan_step && push) || free_push;
    st_waddr = SAW'(count_r);
    st_wdata = cmd.scan_step ? chk_addr_r : num_w;
    st_raddr = SAW'(count_r - CW'(1));
  end

  fica_ram #(.WIDTH(1), .DEPTH(NUM_INODES)) u_bitmap (
    .clk   (clk),
    .we    (bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .raddr (scan_addr_r[AW-1:0]),
    .rdata (bm_rdata)
  );

  fica_ram #(.WIDTH(AW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  always_comb begin
    count_nxt     = count_r;
    scan_addr_nxt = scan_addr_r;
    pend_nxt      = pend_r;
    chk_addr_nxt  = chk_addr_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = cmd.free_op || cmd.pop || cmd.emit_fail;
    out_num_nxt   = out_num_r;
    out_ok_nxt    = out_ok_r;

    if (cmd.clr_step) begin
      clr_addr_nxt = clr_addr_r + AW'(1);
    end
    if (cmd.scan_step) begin
      count_nxt    = cnt_after;
      pend_nxt     = scan_issue;
      chk_addr_nxt = scan_addr_r[AW-1:0];
      if (scan_issue) begin
        scan_addr_nxt = scan_addr_r + (AW+1)'(1);
      end
    end
    if (cmd.scan_init) begin
      scan_addr_nxt = (AW+1)'(ROOT_INDEX + 1);
      pend_nxt      = 1'b0;
    end
    if (cmd.pop) begin
      count_nxt   = count_r - CW'(1);
      out_num_nxt = NUM_W'(st_rdata);
      out_ok_nxt  = 1'b1;
    end
    if (cmd.free_op) begin
      if (free_push) begin
        count_nxt = count_r + CW'(1);
      end
      out_num_nxt = in_inode_number;
      out_ok_nxt  = in_range;
    end
    if (cmd.emit_fail) begin
      out_num_nxt = '0;
      out_ok_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      scan_addr_r <= '0;
      pend_r      <= 1'b0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      scan_addr_r <= scan_addr_nxt;
      pend_r      <= pend_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_addr_r <= chk_addr_nxt;
    out_num_r  <= out_num_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_granted_number = out_num_r;
  assign out_ok             = out_ok_r;

endmodule

// File: sv/free_inode_cache_allocator.sv
// Free inode cache allocator: hands out and takes back inode numbers, after
// a start/busy command. Each result comes back as a single-cycle out_valid
// strobe that the receiver must take; it cannot stall the block.
// After reset, busy stays high while the allocated bitmap is cleared one
// entry per cycle. A free leaves busy low and its result follows in the next
// cycle. An allocate with numbers cached passes through the POP state and its
// result is registered from there. An allocate that finds the cache empty
// first runs the refill scan, one bitmap RAM read per cycle, until STACK_DEPTH
// free numbers are found or the last inode is passed, then goes through LOAD
// and POP (when nothing is free the allocate fails instead). Popping the
// last cached number starts the same scan after the result, holding busy for it.
// Depends on fica_pkg, fica_ctrl, fica_dp and fica_ram.
module free_inode_cache_allocator #(
  parameter int unsigned NUM_INODES  = 512,
  parameter int unsigned STACK_DEPTH = 100
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_op,
  input  logic [fica_pkg::NUM_W-1:0] in_inode_number,
  output logic                       out_valid,
  output logic [fica_pkg::NUM_W-1:0] out_granted_number,
  output logic                       out_ok
);
  import fica_pkg::*;

  cmd_t    cmd;
  status_t status;

  fica_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_op  (in_op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  fica_dp #(
    .NUM_INODES  (NUM_INODES),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .in_inode_number    (in_inode_number),
    .out_valid          (out_valid),
    .out_granted_number (out_granted_number),
    .out_ok             (out_ok)
  );

endmodule

// File: sv/fica_checker.sv
// Port-level checks for the free inode cache allocator, bound to the top level.
// Depends on fica_pkg and free_inode_cache_allocator.
module fica_checker #(
  parameter int unsigned NUM_INODES = 512
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       in_op,
  input logic [fica_pkg::NUM_W-1:0] in_inode_number,
  input logic                       out_valid,
  input logic [fica_pkg::NUM_W-1:0] out_granted_number,
  input logic                       out_ok
);
  import fica_pkg::*;

  a_free_echo: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_op == OP_FREE
    |=> out_valid && out_granted_number == $past(in_inode_number))
    else $error("free transfer not echoed in next cycle");

  a_free_ok: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_op == OP_FREE
    |=> out_ok == (32'($past(in_inode_number)) < NUM_INODES))
    else $error("free status does not match range");

  a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_op == OP_ALLOC |=> busy)
    else $error("allocate transfer did not hold busy");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy) || $past(start))
    else $error("result without a pending request");

endmodule

bind free_inode_cache_allocator fica_checker #(.NUM_INODES(NUM_INODES)) u_fica_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_op              (in_op),
  .in_inode_number    (in_inode_number),
  .out_valid          (out_valid),
  .out_granted_number (out_granted_number),
  .out_ok             (out_ok)
);
